// ===== src/mfu_pkg.sv =====
`default_nettype none

package mfu_pkg;

   // Default number of frames in the set.
   localparam int FRAMES_DEF = 8;

   // Field widths.
   localparam int PAGE_W  = 16;
   localparam int USES_W  = 16;
   localparam int STAMP_W = 32;
   localparam int FAULT_W = 16;
   localparam int CFG_W   = 4;
   localparam int FIDX_W  = 3;

   // Saturation limits.
   localparam logic [USES_W-1:0]  USES_MAX  = {USES_W{1'b1}};
   localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

   // Reset value of the frame count register.
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

   // One frame as held in the frame memory.
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [USES_W-1:0]  uses;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic issue;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_issue;
   } status_type;

endpackage

`default_nettype wire

// ===== src/mfu_ram.sv =====
`default_nettype none

module mfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/mfu_ctrl.sv =====
`default_nettype none

module mfu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire mfu_pkg::status_type status,
   output mfu_pkg::cmd_type         cmd,
   output logic                     busy
);

   import mfu_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/mfu_datapath.sv =====
`default_nettype none

module mfu_datapath #(
   parameter int FRAMES = mfu_pkg::FRAMES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mfu_pkg::cmd_type              cmd,
   output mfu_pkg::status_type                status,
   input  wire logic [mfu_pkg::PAGE_W-1:0]    req_page_number,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [mfu_pkg::CFG_W-1:0]     csr_frames_in_use,
   output logic                               rsp_strobe,
   output logic                               rsp_hit,
   output logic [mfu_pkg::FIDX_W-1:0]         rsp_frame_index,
   output logic                               rsp_evicted_valid,
   output logic [mfu_pkg::PAGE_W-1:0]         rsp_evicted_page,
   output logic [mfu_pkg::FAULT_W-1:0]        rsp_fault_count
);

   import mfu_pkg::*;

   localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   logic [CFG_W-1:0]   cfg_ff;
   logic [7:0]         count_eff;
   logic [IW-1:0]      last_idx;

   logic [PAGE_W-1:0]  page_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               pend_ff;
   logic [IW-1:0]      pend_idx_ff;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_data;

   logic               match_found_ff;
   logic [IW-1:0]      match_idx_ff;
   entry_type          match_ff;
   logic               empty_found_ff;
   logic [IW-1:0]      empty_idx_ff;
   logic [IW-1:0]      best_idx_ff;
   entry_type          best_ff;

   logic [FRAMES-1:0]  valid_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [FAULT_W-1:0] faults_ff;
   logic [FAULT_W-1:0] faults_in;

   logic               cur_valid;
   logic               better;
   logic [IW-1:0]      slot;
   entry_type          wr_entry;

   logic               rsp_strobe_ff;
   logic               rsp_hit_ff;
   logic [FIDX_W-1:0]  rsp_frame_index_ff;
   logic               rsp_evicted_valid_ff;
   logic [PAGE_W-1:0]  rsp_evicted_page_ff;
   logic [FAULT_W-1:0] rsp_fault_count_ff;

   // Frame count register; the user must write it only while idle, the block itself does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         cfg_ff <= csr_frames_in_use;
      end
   end

   // Effective frame count, clamped to one through FRAMES.
   always_comb begin
      count_eff = 8'(cfg_ff);
      if (count_eff == 8'd0) begin
         count_eff = 8'd1;
      end
      if (count_eff > 8'(FRAMES)) begin
         count_eff = 8'(FRAMES);
      end
      last_idx = IW'(count_eff - 8'd1);
   end

   assign status.last_issue = (rd_idx_ff == last_idx);

   // Read address counter and read pipeline tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.issue;
      end
      pend_idx_ff <= rd_idx_ff;
      if (cmd.load) begin
         rd_idx_ff <= '0;
         page_ff   <= req_page_number;
      end else if (cmd.issue) begin
         rd_idx_ff <= rd_idx_ff + IW'(1);
      end
   end

   mfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FRAMES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (slot),
      .wr_data (wr_entry),
      .rd_en   (cmd.issue),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign cur_valid = valid_ff[pend_idx_ff];

   // A frame beats the current victim on a higher count, or an equal count
   // with an earlier load stamp.
   assign better = (rd_entry.uses > best_ff.uses) ||
                   ((rd_entry.uses == best_ff.uses) && (rd_entry.stamp < best_ff.stamp));

   // Scan trackers: first match, first empty frame and best victim.
   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (cmd.load) begin
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
      end else if (pend_ff) begin
         if (!match_found_ff && cur_valid && (rd_entry.page == page_ff)) begin
            match_found_ff <= 1'b1;
         end
         if (!empty_found_ff && !cur_valid) begin
            empty_found_ff <= 1'b1;
         end
      end
      if (pend_ff) begin
         if (!match_found_ff && cur_valid && (rd_entry.page == page_ff)) begin
            match_idx_ff <= pend_idx_ff;
            match_ff     <= rd_entry;
         end
         if (!empty_found_ff && !cur_valid) begin
            empty_idx_ff <= pend_idx_ff;
         end
         if ((pend_idx_ff == '0) || better) begin
            best_idx_ff <= pend_idx_ff;
            best_ff     <= rd_entry;
         end
      end
   end

   // Frame chosen and the entry written back to it.
   always_comb begin
      wr_entry  = '0;
      faults_in = faults_ff;
      if (match_found_ff) begin
         slot     = match_idx_ff;
         wr_entry = match_ff;
         if (match_ff.uses != USES_MAX) begin
            wr_entry.uses = match_ff.uses + USES_W'(1);
         end
      end else begin
         slot = empty_found_ff ? empty_idx_ff : best_idx_ff;
         wr_entry.page  = page_ff;
         wr_entry.uses  = USES_W'(1);
         wr_entry.stamp = stamp_ff;
         if (faults_ff != FAULT_MAX) begin
            faults_in = faults_ff + FAULT_W'(1);
         end
      end
   end

   // Frame occupancy, stamp and fault counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         stamp_ff  <= '0;
         faults_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[slot] <= 1'b1;
         stamp_ff       <= stamp_ff + STAMP_W'(1);
         faults_ff      <= faults_in;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.commit;
      end
      if (cmd.commit) begin
         rsp_hit_ff           <= match_found_ff;
         rsp_frame_index_ff   <= FIDX_W'(slot);
         rsp_evicted_valid_ff <= !match_found_ff && !empty_found_ff;
         rsp_evicted_page_ff  <= (!match_found_ff && !empty_found_ff) ? best_ff.page : '0;
         rsp_fault_count_ff   <= faults_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = rsp_fault_count_ff;

endmodule

`default_nettype wire

// ===== src/mfu_page_replacement.sv =====
`default_nettype none

// Most-frequently-used page replacement over a fully associative frame set.
// A request is taken at a clock edge where start is high and busy is low;
// req_page_number carries the referenced page. Each request gives one
// response, shown for a single cycle with rsp_strobe high: hit, the frame
// now holding the page, the evicted page if any, and the running fault count.
// A request scans the effective frame count of frames, reading the frame
// memory one frame per cycle through its single registered read port; a
// drain state then lets the last read land and a commit state writes back.
// Busy stays high until the write-back is done; the next request may start
// in the response cycle. The receiver cannot stall, so no response is held.
// The frame count is written through csr_valid/csr_ready; the user must do
// so only while idle, and the block itself does not enforce this.
// Reset empties all frames, clears the stamp and fault count and sets the
// frame count to eight; there is no clearing pass.
module mfu_page_replacement #(
   parameter int FRAMES = mfu_pkg::FRAMES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [mfu_pkg::PAGE_W-1:0] req_page_number,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [mfu_pkg::CFG_W-1:0]  csr_frames_in_use,
   output logic                            rsp_strobe,
   output logic                            rsp_hit,
   output logic [mfu_pkg::FIDX_W-1:0]      rsp_frame_index,
   output logic                            rsp_evicted_valid,
   output logic [mfu_pkg::PAGE_W-1:0]      rsp_evicted_page,
   output logic [mfu_pkg::FAULT_W-1:0]     rsp_fault_count
);

   import mfu_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   mfu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Frame memory, scan trackers and result registers.
   mfu_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_page_number   (req_page_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mfu_pkg::*;

   localparam int NUM_FRAMES  = FRAMES_DEF;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int PHASE_ITEMS = 140;
   localparam int NUM_PHASES  = 6;
   // Frame counts for the random phases; the last phase draws its own value.
   localparam logic [19:0] PHASE_FRAMES = {4'd9, 4'd8, 4'd5, 4'd2, 4'd1};

   typedef enum logic {
      ROW_REF,
      ROW_CFG
   } row_kind_type;

   // One response as seen on the rsp_ ports.
   typedef struct packed {
      logic               hit;
      logic [FIDX_W-1:0]  frame;
      logic               ev_valid;
      logic [PAGE_W-1:0]  ev_page;
      logic [FAULT_W-1:0] faults;
   } access_result_type;

   // One line of the directed stimulus table.
   typedef struct {
      row_kind_type      kind;
      logic [15:0]       value;
      bit                typed;
      access_result_type want;
   } step_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [PAGE_W-1:0]   req_page_number = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_frames_in_use = '0;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic [FIDX_W-1:0]   rsp_frame_index;
   logic                rsp_evicted_valid;
   logic [PAGE_W-1:0]   rsp_evicted_page;
   logic [FAULT_W-1:0]  rsp_fault_count;

   // Predictor copy of the frame set and its counters.
   logic [PAGE_W-1:0]   fr_page  [NUM_FRAMES];
   logic                fr_valid [NUM_FRAMES];
   logic [USES_W-1:0]   fr_uses  [NUM_FRAMES];
   logic [STAMP_W-1:0]  fr_stamp [NUM_FRAMES];
   logic [STAMP_W-1:0]  stamp_ctr = '0;
   logic [FAULT_W-1:0]  fault_ctr = '0;
   logic [CFG_W-1:0]    cfg_frames = CFG_RESET;

   access_result_type   pending_results[$];
   step_row_type        dir_rows[$];
   access_result_type   no_result = '0;
   int                  burst_left = 0;
   int                  n_fail = 0;
   int                  n_refs = 0;
   int                  n_hits = 0;
   int                  n_evictions = 0;
   int                  n_cfg = 0;
   int                  cycles = 0;

   mfu_page_replacement #(
      .FRAMES(NUM_FRAMES)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .rsp_strobe        (rsp_strobe),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count)
   );

   // Free-running clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Global watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycles, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // MFU replacement on one reference: search, fill an empty frame, or evict
   // the most used frame with ties to the oldest load and then lowest index.
   task automatic predict_reference(input logic [PAGE_W-1:0] page,
                                    output access_result_type res);
      int  active;
      int  slot;
      bit  found;
      bit  empty;
      logic [STAMP_W-1:0] now;
      active = (cfg_frames == 0) ? 1 : (cfg_frames > NUM_FRAMES) ? NUM_FRAMES
                                                                  : int'(cfg_frames);
      slot   = 0;
      found  = 1'b0;
      empty  = 1'b0;
      now    = stamp_ctr;
      res    = '0;
      stamp_ctr = stamp_ctr + STAMP_W'(1);
      for (int i = 0; i < active; i++) begin
         if (!found && fr_valid[i] && fr_page[i] == page) begin
            slot  = i;
            found = 1'b1;
         end
      end
      if (found) begin
         if (fr_uses[slot] != USES_MAX) fr_uses[slot] = fr_uses[slot] + USES_W'(1);
      end else begin
         for (int i = 0; i < active; i++) begin
            if (!empty && !fr_valid[i]) begin
               slot  = i;
               empty = 1'b1;
            end
         end
         if (!empty) begin
            slot = 0;
            for (int i = 1; i < active; i++) begin
               if (fr_uses[i] > fr_uses[slot] ||
                   (fr_uses[i] == fr_uses[slot] && fr_stamp[i] < fr_stamp[slot]))
                  slot = i;
            end
            res.ev_valid = 1'b1;
            res.ev_page  = fr_page[slot];
         end
         fr_page[slot]  = page;
         fr_valid[slot] = 1'b1;
         fr_uses[slot]  = USES_W'(1);
         fr_stamp[slot] = now;
         if (fault_ctr != FAULT_MAX) fault_ctr = fault_ctr + FAULT_W'(1);
      end
      res.hit    = found;
      res.frame  = slot[FIDX_W-1:0];
      res.faults = fault_ctr;
   endtask

   // Present one reference, honoring the sender's burst and gap pattern.
   task automatic send_reference(input logic [PAGE_W-1:0] page, input bit typed,
                                 input access_result_type typed_want);
      access_result_type want;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      start           <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_reference(page, want);
      pending_results.push_back(typed ? typed_want : want);
      n_refs++;
   endtask

   // Stop sending and wait until every response is in and the block is idle.
   task automatic drain_requests();
      start <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Write the frame count register while the block is idle.
   task automatic write_frame_count(input logic [CFG_W-1:0] value);
      drain_requests();
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      cfg_frames = value;
      n_cfg++;
   endtask

   task automatic add_row(input row_kind_type kind, input logic [15:0] value,
                          input bit typed, input logic hit, input int frame,
                          input logic ev_valid, input logic [15:0] ev_page,
                          input int faults);
      step_row_type row;
      row.kind           = kind;
      row.value          = value;
      row.typed          = typed;
      row.want.hit       = hit;
      row.want.frame     = frame[FIDX_W-1:0];
      row.want.ev_valid  = ev_valid;
      row.want.ev_page   = ev_page;
      row.want.faults    = faults[FAULT_W-1:0];
      dir_rows.push_back(row);
   endtask

   // Response checker: each strobe is compared with the oldest prediction.
   always @(posedge clock) begin
      access_result_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_hit) n_hits++;
         if (rsp_evicted_valid) n_evictions++;
         if (pending_results.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
               $display("ERROR %0t: response with no request outstanding", $realtime);
         end else begin
            want = pending_results.pop_front();
            if (want.hit !== rsp_hit || want.frame !== rsp_frame_index ||
                want.ev_valid !== rsp_evicted_valid ||
                want.ev_page !== rsp_evicted_page ||
                want.faults !== rsp_fault_count) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("ERROR %0t: exp hit=%0b frame=%0d evict=%0b/%h faults=%0d",
                           $realtime, want.hit, want.frame, want.ev_valid,
                           want.ev_page, want.faults,
                           " got hit=%0b frame=%0d evict=%0b/%h faults=%0d",
                           rsp_hit, rsp_frame_index,
                           rsp_evicted_valid, rsp_evicted_page, rsp_fault_count);
            end
         end
      end
   end

   // Stimulus.
   initial begin
      logic [PAGE_W-1:0] pool[12];
      logic [CFG_W-1:0]  phase_frames;
      logic [PAGE_W-1:0] page;
      int                pool_size;

      for (int i = 0; i < NUM_FRAMES; i++) begin
         fr_page[i]  = '0;
         fr_valid[i] = 1'b0;
         fr_uses[i]  = '0;
         fr_stamp[i] = '0;
      end

      // Directed table: fill from reset, evict by count and by age, shrink the
      // active set below resident frames, and hit duplicate copies of a page.
      add_row(ROW_REF, 16'h0000, 1, 0, 0, 0, 16'h0000, 1);
      add_row(ROW_REF, 16'hFFFF, 1, 0, 1, 0, 16'h0000, 2);
      add_row(ROW_REF, 16'h0000, 1, 1, 0, 0, 16'h0000, 2);
      add_row(ROW_REF, 16'hAAAA, 1, 0, 2, 0, 16'h0000, 3);
      add_row(ROW_REF, 16'h5555, 1, 0, 3, 0, 16'h0000, 4);
      add_row(ROW_REF, 16'h0001, 1, 0, 4, 0, 16'h0000, 5);
      add_row(ROW_REF, 16'h0002, 1, 0, 5, 0, 16'h0000, 6);
      add_row(ROW_REF, 16'h0003, 1, 0, 6, 0, 16'h0000, 7);
      add_row(ROW_REF, 16'h0004, 1, 0, 7, 0, 16'h0000, 8);
      // Set is full: the twice-used frame goes first, then the oldest load.
      add_row(ROW_REF, 16'h1234, 1, 0, 0, 1, 16'h0000, 9);
      add_row(ROW_REF, 16'h5678, 1, 0, 1, 1, 16'hFFFF, 10);
      // A count of zero behaves as one frame.
      add_row(ROW_CFG, 16'd0, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'h0004, 1, 0, 0, 1, 16'h1234, 11);
      // A count above the frame total behaves as all frames; the page now
      // sits in two frames and the lower one wins, the idle frames kept theirs.
      add_row(ROW_CFG, 16'd15, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'h0004, 1, 1, 0, 0, 16'h0000, 11);
      add_row(ROW_REF, 16'h0003, 1, 1, 6, 0, 16'h0000, 11);
      add_row(ROW_CFG, 16'd3, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'h0003, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'h8001, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_CFG, 16'd8, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'h0003, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'h7FFE, 0, 0, 0, 0, 16'h0000, 0);
      add_row(ROW_REF, 16'hFFFF, 0, 0, 0, 0, 16'h0000, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CFG)
            write_frame_count(dir_rows[r].value[CFG_W-1:0]);
         else
            send_reference(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].want);
      end

      // Random phases: a small working set of random pages keeps hits and
      // evictions frequent, with some references from the full page range.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         phase_frames = (ph == NUM_PHASES - 1) ? CFG_W'($urandom_range(0, 15))
                                               : PHASE_FRAMES[ph*4 +: 4];
         write_frame_count(phase_frames);
         pool_size = $urandom_range(2, 12);
         for (int i = 0; i < 12; i++) pool[i] = PAGE_W'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 7)
               page = pool[$urandom_range(0, pool_size - 1)];
            else
               page = PAGE_W'($urandom);
            send_reference(page, 1'b0, no_result);
            // Once mid-phase, let every outstanding response come back.
            if (ph == 2 && n == PHASE_ITEMS / 2) drain_requests();
         end
      end

      drain_requests();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) n_fail += pending_results.size();

      $display("Checked %0d page references (%0d hits, %0d evictions) over %0d frame counts.",
               n_refs, n_hits, n_evictions, n_cfg);
      $display("Covered fill, eviction by count and age, out-of-range counts; %0d failed.",
               n_fail);
      if (n_fail == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
